// File: src/tkns_pkg.sv
// shared types and codes for the toroidal k-nearest search unit
// used by tkns_ctrl, tkns_dp and the top level; no dependencies
package tkns_pkg;

	// input word kinds carried on s_tuser
	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_QUERY = 2'd2
	} mode_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 8'd1;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear_tbl;
		logic load_star;
		logic start_query;
		logic scan_step;
		logic emit_step;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic table_empty;
		logic scan_last;
		logic pipe_busy;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

// File: src/tkns_ctrl.sv
// controller state machine: input acceptance, scan, drain and emit sequencing
// depends on tkns_pkg; drives the datapath through cmd_t, reads status_t
module tkns_ctrl import tkns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  in_mode,
	output logic        in_ready,
	input  status_t     st,
	output cmd_t        cmd
);

	state_t state_q, state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_mode == MODE_QUERY) begin
					state_d = st.table_empty ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!st.pipe_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.out_free && st.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (in_mode)
						MODE_CLEAR: cmd.clear_tbl   = 1'b1;
						MODE_LOAD:  cmd.load_star   = 1'b1;
						MODE_QUERY: cmd.start_query = 1'b1;
						default:    cmd             = '0;
					endcase
				end
			end
			ST_SCAN:  cmd.scan_step = 1'b1;
			ST_DRAIN: cmd           = '0;
			ST_EMIT:  cmd.emit_step = st.out_free;
			default:  cmd           = '0;
		endcase
	end

	// a new word is only taken once the scan pipeline is empty
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !st.pipe_busy)
		else $error("input taken while scan pipeline busy");

	// never read the table when it holds no star
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> !st.table_empty)
		else $error("scan step on empty table");

	// the last emitted word returns the controller to idle
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_step && st.emit_last) |=> in_ready)
		else $error("not idle after last result word");

endmodule

// File: src/tkns_dp.sv
// datapath: star table memory, distance pipeline, sorted best list, output register
// depends on tkns_pkg; controlled by tkns_ctrl through cmd_t and status_t
module tkns_dp import tkns_pkg::*; #(
	parameter int MAX_STARS     = 1024,
	parameter int MAX_NEIGHBORS = 16,
	parameter int COORD_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]          cfg_wdata,
	// input word fields
	input  logic [15:0]          star_u,
	input  logic [15:0]          star_v,
	input  logic [15:0]          query_u,
	input  logic [15:0]          query_v,
	input  logic [31:0]          radius_sq,
	input  logic [4:0]           max_count,
	// result word
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic [9:0]           star_index,
	output logic [31:0]          distance_sq,
	output logic [4:0]           result_count,
	output logic                 last,
	// control
	input  cmd_t                 cmd,
	output status_t              st
);

	localparam int SW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
	localparam int TW = $clog2(MAX_STARS + 1);
	localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam int C  = COORD_BITS;

	// configuration registers
	logic [15:0] world_w_q, world_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_w_q <= 16'd4096;
			world_h_q <= 16'd4096;
		end else if (cfg_we) begin
			if (cfg_idx == REG_WORLD_WIDTH) begin
				world_w_q <= cfg_wdata;
			end
			if (cfg_idx == REG_WORLD_HEIGHT) begin
				world_h_q <= cfg_wdata;
			end
		end
	end

	// star count
	logic [TW-1:0] star_total_q;
	logic          tbl_full;

	assign tbl_full = 32'(star_total_q) >= MAX_STARS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_total_q <= '0;
		end else if (cmd.clear_tbl) begin
			star_total_q <= '0;
		end else if (cmd.load_star && !tbl_full) begin
			star_total_q <= star_total_q + 1'b1;
		end
	end

	// query parameters
	logic [C-1:0]  qu_q, qv_q;
	logic [31:0]   radius_q;
	logic [CW-1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.start_query) begin
			k_q <= ({27'd0, max_count} > 32'(MAX_NEIGHBORS)) ? CW'(MAX_NEIGHBORS)
				: CW'(max_count);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			qu_q     <= query_u[C-1:0];
			qv_q     <= query_v[C-1:0];
			radius_q <= radius_sq;
		end
	end

	// scan address counter
	logic [SW-1:0] scan_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
		end else if (cmd.start_query) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
		end
	end

	// star table, one write and one registered read per cycle
	logic [2*C-1:0] star_mem [MAX_STARS];
	logic [2*C-1:0] rd_s1;
	logic [SW-1:0]  idx_s1;

	always_ff @(posedge clk) begin
		if (cmd.load_star && !tbl_full) begin
			star_mem[SW'(star_total_q)] <= {star_v[C-1:0], star_u[C-1:0]};
		end
		if (cmd.scan_step) begin
			rd_s1 <= star_mem[scan_idx_q];
		end
		idx_s1 <= scan_idx_q;
	end

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 2: per-axis absolute difference
	logic [C-1:0]  su_s1, sv_s1;
	logic [C-1:0]  du_s2, dv_s2;
	logic [SW-1:0] idx_s2;

	assign su_s1 = rd_s1[C-1:0];
	assign sv_s1 = rd_s1[2*C-1:C];

	always_ff @(posedge clk) begin
		du_s2  <= (su_s1 > qu_q) ? su_s1 - qu_q : qu_q - su_s1;
		dv_s2  <= (sv_s1 > qv_q) ? sv_s1 - qv_q : qv_q - sv_s1;
		idx_s2 <= idx_s1;
	end

	// stage 3: wrap around the world when past half its size
	logic [15:0]   du16, dv16;
	logic [15:0]   wu_s3, wv_s3;
	logic [SW-1:0] idx_s3;

	assign du16 = 16'(du_s2);
	assign dv16 = 16'(dv_s2);

	always_ff @(posedge clk) begin
		if ({1'b0, du16, 1'b0} > {2'b00, world_w_q}) begin
			wu_s3 <= (world_w_q > du16) ? world_w_q - du16 : du16 - world_w_q;
		end else begin
			wu_s3 <= du16;
		end
		if ({1'b0, dv16, 1'b0} > {2'b00, world_h_q}) begin
			wv_s3 <= (world_h_q > dv16) ? world_h_q - dv16 : dv16 - world_h_q;
		end else begin
			wv_s3 <= dv16;
		end
		idx_s3 <= idx_s2;
	end

	// stage 4: squares
	logic [31:0]   squ_s4, sqv_s4;
	logic [SW-1:0] idx_s4;

	always_ff @(posedge clk) begin
		squ_s4 <= wu_s3 * wu_s3;
		sqv_s4 <= wv_s3 * wv_s3;
		idx_s4 <= idx_s3;
	end

	// stage 5: sum and radius check
	logic [32:0]   dsum;
	logic [31:0]   dsq_s5;
	logic          within_s5;
	logic [SW-1:0] idx_s5;

	assign dsum = {1'b0, squ_s4} + {1'b0, sqv_s4};

	always_ff @(posedge clk) begin
		dsq_s5    <= dsum[31:0];
		within_s5 <= dsum <= {1'b0, radius_q};
		idx_s5    <= idx_s4;
	end

	// sorted best list, insertion by parallel compare and shift
	logic [31:0]         best_d_q  [MAX_NEIGHBORS];
	logic [SW-1:0]       best_i_q  [MAX_NEIGHBORS];
	logic [31:0]         nxt_d     [MAX_NEIGHBORS];
	logic [SW-1:0]       nxt_i     [MAX_NEIGHBORS];
	logic [31:0]         prv_d     [MAX_NEIGHBORS];
	logic [SW-1:0]       prv_i     [MAX_NEIGHBORS];
	logic [MAX_NEIGHBORS-1:0] gt, prev_gt;
	logic [CW-1:0]       best_total_q;
	logic                ins;

	always_comb begin
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			gt[j] = (CW'(j) < best_total_q) && (best_d_q[j] > dsq_s5);
		end
		prev_gt[0] = 1'b0;
		prv_d[0]   = dsq_s5;
		prv_i[0]   = idx_s5;
		for (int j = 1; j < MAX_NEIGHBORS; j++) begin
			prev_gt[j] = gt[j-1];
			prv_d[j]   = best_d_q[j-1];
			prv_i[j]   = best_i_q[j-1];
		end
		ins = v_s5 && within_s5 && ((best_total_q < k_q) || (|gt));
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			nxt_d[j] = best_d_q[j];
			nxt_i[j] = best_i_q[j];
			if (ins && CW'(j) < k_q) begin
				if (prev_gt[j]) begin
					nxt_d[j] = prv_d[j];
					nxt_i[j] = prv_i[j];
				end else if (gt[j] || CW'(j) == best_total_q) begin
					nxt_d[j] = dsq_s5;
					nxt_i[j] = idx_s5;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_NEIGHBORS; j++) begin
			best_d_q[j] <= nxt_d[j];
			best_i_q[j] <= nxt_i[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_total_q <= '0;
		end else if (cmd.start_query) begin
			best_total_q <= '0;
		end else if (ins && best_total_q < k_q) begin
			best_total_q <= best_total_q + 1'b1;
		end
	end

	// emit counter
	logic [NW-1:0] emit_idx_q;
	logic          emit_last;

	assign emit_last = (best_total_q == '0) ||
		({1'b0, emit_idx_q} + 1'b1 == (NW+1)'(best_total_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
		end else if (cmd.start_query) begin
			emit_idx_q <= '0;
		end else if (cmd.emit_step) begin
			emit_idx_q <= emit_idx_q + 1'b1;
		end
	end

	// output register
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			if (best_total_q == '0) begin
				found        <= 1'b0;
				star_index   <= '0;
				distance_sq  <= '0;
				result_count <= '0;
			end else begin
				found        <= 1'b1;
				star_index   <= 10'(best_i_q[emit_idx_q]);
				distance_sq  <= best_d_q[emit_idx_q];
				result_count <= 5'(best_total_q);
			end
			last <= emit_last;
		end
	end

	assign out_valid = out_valid_q;

	// status
	assign st.table_empty = (star_total_q == '0);
	assign st.scan_last   = ({1'b0, scan_idx_q} + 1'b1) == (SW+1)'(star_total_q);
	assign st.pipe_busy   = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign st.emit_last   = emit_last;
	assign st.out_free    = out_free;

	// list never grows past the requested count
	a_total_k: assert property (@(posedge clk) disable iff (!arst_n)
		best_total_q <= k_q)
		else $error("best list larger than requested count");

	// a result word is only loaded into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> out_free)
		else $error("output register overwritten");

	// table count stays within capacity
	a_tbl_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(star_total_q) <= MAX_STARS)
		else $error("star count beyond table size");

endmodule

// File: src/toroidal_k_nearest_search_unit.sv
// top level of the toroidal k-nearest star search unit
// depends on tkns_pkg, tkns_ctrl and tkns_dp
//
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tdata (104b), s_tuser = mode
// m_*      out  m_tvalid / m_tready    m_tdata (48b), m_tuser = found, m_tlast = last
// cfg_*    in   cfg_valid / cfg_ready  cfg_index (8b), cfg_data (16b)
//
// clear and load words are handled in the idle state; a query scans every stored
// star through the one table read port and the five-stage distance pipeline (no
// scan on an empty table), lets the pipeline drain, then emits one result word per
// cycle while the output is free (1 to MAX_NEIGHBORS words, or one not-found word)
// arst_n clears the star count, the list count and all handshake state;
// the table itself needs no clearing pass
// output stalls hold the emit sequence; a new input word is taken while the
// last result word still waits in the output register
module toroidal_k_nearest_search_unit import tkns_pkg::*; #(
	parameter int MAX_STARS     = 1024,
	parameter int MAX_NEIGHBORS = 16,
	parameter int COORD_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// star_u[15:0] star_v[31:16] query_u[47:32] query_v[63:48]
	// radius_sq[95:64] max_count[100:96], zero pad to 104
	input  logic [103:0]         s_tdata,
	// mode[1:0]
	input  logic [1:0]           s_tuser,
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// star_index[9:0] distance_sq[41:10] result_count[46:42], zero pad to 48
	output logic [47:0]          m_tdata,
	// found[0]
	output logic                 m_tuser,
	output logic                 m_tlast,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cmd_t        cmd;
	status_t     st;
	logic [9:0]  star_index;
	logic [31:0] distance_sq;
	logic [4:0]  result_count;

	assign cfg_ready = 1'b1;

	// controller
	tkns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	tkns_dp #(
		.MAX_STARS     (MAX_STARS),
		.MAX_NEIGHBORS (MAX_NEIGHBORS),
		.COORD_BITS    (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_idx      (cfg_index),
		.cfg_wdata    (cfg_data),
		.star_u       (s_tdata[15:0]),
		.star_v       (s_tdata[31:16]),
		.query_u      (s_tdata[47:32]),
		.query_v      (s_tdata[63:48]),
		.radius_sq    (s_tdata[95:64]),
		.max_count    (s_tdata[100:96]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.found        (m_tuser),
		.star_index   (star_index),
		.distance_sq  (distance_sq),
		.result_count (result_count),
		.last         (m_tlast),
		.cmd          (cmd),
		.st           (st)
	);

	// result word packing
	assign m_tdata = {1'b0, result_count, distance_sq, star_index};

endmodule

// File: sim/tb_toroidal_k_nearest_search_unit.sv
// testbench for the toroidal k-nearest star search unit: directed words, a full star table
// and randomised phases over several world sizes, every result word checked in order
// depends on tkns_pkg and toroidal_k_nearest_search_unit
module tb_toroidal_k_nearest_search_unit;
	import tkns_pkg::*;

	localparam int STAR_DEPTH    = 1024;
	localparam int NEIGHBOURS    = 16;
	localparam int QUIET_LIMIT   = 6000;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// one result word as the block presents it
	typedef struct packed {
		logic        found;
		logic [9:0]  star_idx;
		logic [31:0] dist_sq;
		logic [4:0]  count;
		logic        is_last;
	} neighbour_t;

	localparam neighbour_t NOT_FOUND = {1'b0, 10'd0, 32'd0, 5'd0, 1'b1};

	// one input word; fixed_exp marks rows whose answer is the not-found word
	typedef struct {
		logic [1:0]  mode;
		logic [15:0] su;
		logic [15:0] sv;
		logic [15:0] qu;
		logic [15:0] qv;
		logic [31:0] radius;
		logic [4:0]  want;
		bit          fixed_exp;
	} word_row_t;

	// directed words: empty table, extremes, ties, wrap-around, unused mode, clear
	word_row_t directed_rows [0:20] = '{
		'{MODE_QUERY,  16'd0,     16'd0,     16'd500,   16'd500,   32'hFFFF_FFFF, 5'd16, 1'b1},
		'{MODE_UNUSED, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF, 5'd16, 1'b0},
		'{MODE_LOAD,   16'd0,     16'd0,     16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_LOAD,   16'hFFFF,  16'hFFFF,  16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_LOAD,   16'd4095,  16'd0,     16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_LOAD,   16'd2048,  16'd2048,  16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_LOAD,   16'd100,   16'd200,   16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_LOAD,   16'd100,   16'd200,   16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd0,     16'd0,     32'hFFFF_FFFF, 5'd16, 1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd0,     16'd0,     32'd0,         5'd16, 1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd100,   16'd200,   32'hFFFF_FFFF, 5'd0,  1'b1},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd1234,  16'd567,   32'd0,         5'd16, 1'b1},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd100,   16'd200,   32'hFFFF_FFFF, 5'd1,  1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'hFFFF,  16'hFFFF,  32'd50000,     5'd16, 1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd32768, 16'd32768, 32'hFFFF_FFFF, 5'd16, 1'b0},
		'{MODE_CLEAR,  16'd0,     16'd0,     16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'd0,     16'd0,     32'hFFFF_FFFF, 5'd16, 1'b1},
		'{MODE_LOAD,   16'hAAAA,  16'h5555,  16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_LOAD,   16'h5555,  16'hAAAA,  16'd0,     16'd0,     32'd0,         5'd0,  1'b0},
		'{MODE_QUERY,  16'd0,     16'd0,     16'hAAAA,  16'h5555,  32'h8000_0000, 5'd2,  1'b0},
		'{MODE_CLEAR,  16'd0,     16'd0,     16'd0,     16'd0,     32'd0,         5'd0,  1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [103:0]         s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b1;
	logic [47:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	// predictor copy of the star table and world size
	logic [15:0] tab_u [STAR_DEPTH];
	logic [15:0] tab_v [STAR_DEPTH];
	int          star_cnt = 0;
	logic [15:0] world_w = 16'd4096;
	logic [15:0] world_h = 16'd4096;
	logic [15:0] hot_u = 16'd0;
	logic [15:0] hot_v = 16'd0;

	neighbour_t  results_due [$];
	neighbour_t  head_nb;
	int          errors = 0;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;
	bit          tail_calm = 1'b0;

	always #4 clk = ~clk;

	toroidal_k_nearest_search_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// per-axis distance folded around the world size
	function automatic int unsigned axis_gap(input int unsigned a, input int unsigned b,
			input int unsigned size);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		if (2 * d > size) d = (size > d) ? size - d : d - size;
		return d;
	endfunction

	// sorted nearest list for one query, queued as expected result words
	task automatic predict_query(input logic [15:0] qu, input logic [15:0] qv,
			input logic [31:0] radius, input logic [4:0] want);
		int unsigned     k, kept, pos;
		longint unsigned dx, dy, dsq;
		logic [9:0]      keep_idx [NEIGHBOURS];
		logic [31:0]     keep_dist [NEIGHBOURS];
		neighbour_t      nb;
		k = (want > NEIGHBOURS) ? NEIGHBOURS : want;
		kept = 0;
		for (int i = 0; i < star_cnt; i++) begin
			dx = axis_gap(tab_u[i], qu, world_w);
			dy = axis_gap(tab_v[i], qv, world_h);
			dsq = dx * dx + dy * dy;
			if (dsq <= radius) begin
				// a tie stays behind the entries already held
				pos = kept;
				while (pos > 0 && keep_dist[pos-1] > dsq) pos--;
				if (kept < k) begin
					for (int j = kept; j > pos; j--) begin
						keep_idx[j] = keep_idx[j-1];
						keep_dist[j] = keep_dist[j-1];
					end
					keep_idx[pos] = 10'(i);
					keep_dist[pos] = 32'(dsq);
					kept++;
				end else if (pos < k) begin
					for (int j = k - 1; j > pos; j--) begin
						keep_idx[j] = keep_idx[j-1];
						keep_dist[j] = keep_dist[j-1];
					end
					keep_idx[pos] = 10'(i);
					keep_dist[pos] = 32'(dsq);
				end
			end
		end
		if (kept == 0) begin
			results_due.push_back(NOT_FOUND);
		end else begin
			for (int i = 0; i < kept; i++) begin
				nb.found = 1'b1;
				nb.star_idx = keep_idx[i];
				nb.dist_sq = keep_dist[i];
				nb.count = 5'(kept);
				nb.is_last = (i == kept - 1);
				results_due.push_back(nb);
			end
		end
	endtask

	// state update for one accepted input word
	task automatic apply_word(input word_row_t r);
		case (r.mode)
			MODE_CLEAR: begin
				star_cnt = 0;
			end
			MODE_LOAD: begin
				// loads into a full table are dropped
				if (star_cnt < STAR_DEPTH) begin
					tab_u[star_cnt] = r.su;
					tab_v[star_cnt] = r.sv;
					star_cnt++;
				end
			end
			MODE_QUERY: begin
				predict_query(r.qu, r.qv, r.radius, r.want);
			end
			default: ;
		endcase
	endtask

	// present one input word, with an optional gap before it
	task automatic send_word(input word_row_t r);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.mode;
		s_tdata <= {3'b000, r.want, r.radius, r.qv, r.qu, r.sv, r.su};
		do @(posedge clk); while (!s_tready);
		if (r.fixed_exp) results_due.push_back(NOT_FOUND);
		else apply_word(r);
	endtask

	// stop sending until every expected word is back and the block has settled
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both world size registers, written while the block is idle
	task automatic set_world(input logic [15:0] w, input logic [15:0] h);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= REG_WORLD_WIDTH;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		world_w = w;
		cfg_index <= REG_WORLD_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		world_h = h;
		cfg_valid <= 1'b0;
	endtask

	// random word: mostly loads and queries near a hot spot, some clears and noise
	function automatic word_row_t random_row();
		word_row_t   r;
		int unsigned pick, sel;
		r = '{MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom, 5'($urandom_range(0, 16)), 1'b0};
		pick = $urandom_range(0, 99);
		if (pick < 3) r.mode = MODE_UNUSED;
		else if (pick < 7 || (star_cnt >= 40 && pick < 30)) r.mode = MODE_CLEAR;
		else if (pick < 60) r.mode = MODE_LOAD;
		else r.mode = MODE_QUERY;

		// star position
		sel = $urandom_range(0, 9);
		if (sel >= 3 && sel < 7) begin
			r.su = hot_u + 16'($urandom_range(0, 127)) - 16'd64;
			r.sv = hot_v + 16'($urandom_range(0, 127)) - 16'd64;
		end else if (sel == 7 && star_cnt > 0) begin
			r.su = tab_u[star_cnt-1];
			r.sv = tab_v[star_cnt-1];
		end else if (sel >= 8) begin
			r.su = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
				: world_w - 16'($urandom_range(1, 3));
			r.sv = $urandom_range(0, 1) ? 16'($urandom_range(0, 3))
				: world_h - 16'($urandom_range(1, 3));
		end

		// query point
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			r.qu = hot_u + 16'($urandom_range(0, 127)) - 16'd64;
			r.qv = hot_v + 16'($urandom_range(0, 127)) - 16'd64;
		end else if (sel < 7 && star_cnt > 0) begin
			pick = $urandom_range(0, star_cnt - 1);
			r.qu = tab_u[pick];
			r.qv = tab_v[pick];
		end

		// search radius and neighbour count
		sel = $urandom_range(0, 19);
		if (sel < 5) r.radius = $urandom;
		else if (sel < 12) r.radius = $urandom_range(0, 20000);
		else if (sel < 15) r.radius = 32'd0;
		else if (sel < 17) r.radius = 32'hFFFF_FFFF;
		else r.radius = $urandom_range(0, 1 << 24);
		sel = $urandom_range(0, 9);
		if (sel < 7) r.want = 5'($urandom_range(1, 16));
		else if (sel < 8) r.want = 5'd0;
		else r.want = 5'd16;
		return r;
	endfunction

	// one world setting followed by a run of random words
	task automatic run_phase(input logic [15:0] w, input logic [15:0] h, input int n,
			input bit gaps);
		word_row_t r;
		set_world(w, h);
		idle_on = gaps;
		hot_u = (w > 1) ? 16'($urandom_range(0, w - 1)) : 16'($urandom);
		hot_v = (h > 1) ? 16'($urandom_range(0, h - 1)) : 16'($urandom);
		for (int i = 0; i < n; i++) begin
			r = random_row();
			send_word(r);
			if ($urandom_range(0, 39) == 0) wait_drained();
		end
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$error("result word with nothing expected: found %0d star_index %0d",
					m_tuser, m_tdata[9:0]);
				errors++;
			end else begin
				head_nb = results_due.pop_front();
				if (m_tuser !== head_nb.found) begin
					$error("found: expected %0d, got %0d", head_nb.found, m_tuser);
					errors++;
				end
				if (m_tdata[9:0] !== head_nb.star_idx) begin
					$error("star_index: expected %0d, got %0d", head_nb.star_idx,
						m_tdata[9:0]);
					errors++;
				end
				if (m_tdata[41:10] !== head_nb.dist_sq) begin
					$error("distance_sq: expected %0d, got %0d", head_nb.dist_sq,
						m_tdata[41:10]);
					errors++;
				end
				if (m_tdata[46:42] !== head_nb.count) begin
					$error("result_count: expected %0d, got %0d", head_nb.count,
						m_tdata[46:42]);
					errors++;
				end
				if (m_tlast !== head_nb.is_last) begin
					$error("last: expected %0d, got %0d", head_nb.is_last, m_tlast);
					errors++;
				end
			end
		end
		if (tail_calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= (stall_left == 0);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles in which no word moves on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		word_row_t r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset world size
		foreach (directed_rows[i]) send_word(directed_rows[i]);

		// fill the table past its depth, then scan it whole
		for (int i = 0; i < STAR_DEPTH + 2; i++) begin
			r = '{MODE_LOAD, 16'($urandom), 16'($urandom), 16'd0, 16'd0, 32'd0, 5'd0, 1'b0};
			send_word(r);
		end
		r = '{MODE_QUERY, 16'd0, 16'd0, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF,
			5'd16, 1'b0};
		send_word(r);
		r = '{MODE_QUERY, 16'd0, 16'd0, 16'($urandom), 16'($urandom),
			$urandom_range(0, 1 << 20), 5'd5, 1'b0};
		send_word(r);
		r = '{MODE_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 5'd0, 1'b0};
		send_word(r);

		// random phases over the world size extremes and a zero size
		run_phase(16'd1, 16'd65535, 70, 1'b1);
		run_phase(16'd65535, 16'd1, 70, 1'b1);
		run_phase(16'd0, 16'd0, 60, 1'b1);
		run_phase(16'd100, 16'd37, 70, 1'b0);
		run_phase(16'd65535, 16'd65535, 70, 1'b1);
		run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 70, 1'b1);
		tail_calm = 1'b1;
		run_phase(16'd4096, 16'd4096, 60, 1'b0);

		wait_drained();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: sim.f
src/tkns_pkg.sv
src/tkns_ctrl.sv
src/tkns_dp.sv
src/toroidal_k_nearest_search_unit.sv
sim/tb_toroidal_k_nearest_search_unit.sv
